// ----- rtl/quant_block_repack_core_assert.svh -----
// assertion macros for the block repacker
`ifndef QUANT_BLOCK_REPACK_CORE_ASSERT_SVH
`define QUANT_BLOCK_REPACK_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define QBR_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("assertion failed");
`define QBR_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define QBR_ASSERT(lbl, clk, rstn, prop)
`define QBR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- rtl/qbr_pkg.sv -----
package qbr_pkg;
	localparam int CmdDepth = 6;

	localparam logic [1:0] FMT_Q40 = 2'd0;
	localparam logic [1:0] FMT_Q41 = 2'd1;

	localparam logic [1:0] KIND_WEIGHT = 2'd0;
	localparam logic [1:0] KIND_SCALE  = 2'd1;
	localparam logic [1:0] KIND_BIAS   = 2'd2;

	localparam logic [5:0] LEN_Q40 = 6'd18;
	localparam logic [5:0] LEN_Q41 = 6'd20;
	localparam logic [5:0] LEN_Q80 = 6'd34;

	localparam logic [3:0] NIB_MASK = 4'hf;
	localparam logic [7:0] TOP_BIT  = 8'h80;

	typedef enum logic [2:0] {
		OP_SCALE,
		OP_SCALE_BIAS,
		OP_BIAS,
		OP_BYTE,
		OP_BYTE_FLUSH
	} op_t;

	typedef struct packed {
		op_t             op;
		logic [15:0]     val;
		logic [15:0]     bias;
		logic            last;
		logic [7:0][7:0] hi;
	} cmd_t;

	// h * -(2^k), exact float16
	function automatic logic [15:0] neg_pow2_scale(input logic [15:0] h, input logic [2:0] k);
		logic        sign;
		logic [4:0]  ex;
		logic [9:0]  man;
		logic [5:0]  ex_sum;
		logic [16:0] v;
		logic [4:0]  p;
		logic [16:0] sh;
		logic [15:0] r;
		sign   = ~h[15];
		ex     = h[14:10];
		man    = h[9:0];
		ex_sum = {1'b0, ex} + {3'b000, k};
		v      = {7'd0, man} << k;
		p      = 5'd10;
		for (int i = 11; i < 17; i++) begin
			if (v[i])
				p = 5'(i);
		end
		sh = v >> (p - 5'd10);
		if (ex == 5'd31) begin
			if (man != 10'd0)
				r = h;
			else
				r = {sign, 15'h7c00};
		end else if (ex != 5'd0) begin
			if (ex_sum >= 6'd31)
				r = {sign, 15'h7c00};
			else
				r = {sign, ex_sum[4:0], man};
		end else if (v < 17'd1024) begin
			r = {sign, v[14:0]};
		end else begin
			r = {sign, p - 5'd9, sh[9:0]};
		end
		return r;
	endfunction
endpackage

// ----- rtl/qbr_front.sv -----
module qbr_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_wdata,
	input  logic           in_fire,
	input  logic [7:0]     raw_byte,
	output logic           cmd_push,
	output qbr_pkg::cmd_t  cmd
);
	import qbr_pkg::*;

	logic [1:0]      mode_q;
	logic [5:0]      pos_q;
	logic [7:0]      low_q;
	logic [3:0]      pend_q;
	logic [7:0][7:0] hi_q;

	logic            q8, q41;
	logic [5:0]      len, ds, pos_next, jj;
	logic [2:0]      k;
	logic [15:0]     scale;
	logic [7:0][7:0] hi_next;
	logic            has_cmd;

	always_comb begin
		q8       = mode_q[1];
		q41      = (mode_q == FMT_Q41);
		len      = q8 ? LEN_Q80 : (q41 ? LEN_Q41 : LEN_Q40);
		ds       = q41 ? 6'd4 : 6'd2;
		jj       = pos_q - ds;
		k        = jj[3:1];
		scale    = {raw_byte, low_q};
		pos_next = (pos_q + 6'd1 >= len) ? 6'd0 : pos_q + 6'd1;
		hi_next  = hi_q;
		has_cmd  = 1'b0;
		cmd      = '0;
		cmd.op   = OP_BYTE;
		if (pos_q == 6'd0) begin
			has_cmd = 1'b0;
		end else if (pos_q == 6'd1) begin
			has_cmd  = 1'b1;
			cmd.op   = q41 ? OP_SCALE : OP_SCALE_BIAS;
			cmd.val  = scale;
			cmd.bias = neg_pow2_scale(scale, q8 ? 3'd7 : 3'd3);
		end else if (pos_q < ds) begin
			if (pos_q != 6'd2) begin
				has_cmd = 1'b1;
				cmd.op  = OP_BIAS;
				cmd.val = scale;
			end
		end else if (q8) begin
			has_cmd  = 1'b1;
			cmd.val  = {8'd0, raw_byte ^ TOP_BIT};
			cmd.last = (pos_q == len - 6'd1);
		end else if (!jj[0]) begin
			hi_next[k] = {4'd0, raw_byte[7:4]};
		end else begin
			hi_next[k] = {raw_byte[7:4], hi_q[k][3:0]};
			has_cmd    = 1'b1;
			cmd.val    = {8'd0, raw_byte[3:0] & NIB_MASK, pend_q};
			// last low byte also carries the high bytes out
			if (k == 3'd7) begin
				cmd.op = OP_BYTE_FLUSH;
				cmd.hi = hi_next;
			end
		end
		cmd_push = in_fire && has_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= FMT_Q40;
			pos_q  <= '0;
			low_q  <= '0;
			pend_q <= '0;
			hi_q   <= '0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
			pos_q  <= '0;
		end else if (in_fire) begin
			pos_q <= pos_next;
			hi_q  <= hi_next;
			if (pos_q == 6'd0 || pos_q == 6'd2)
				low_q <= raw_byte;
			if (!q8 && pos_q >= ds && !jj[0])
				pend_q <= raw_byte[3:0];
		end
	end
endmodule

// ----- rtl/qbr_cmd_fifo.sv -----
module qbr_cmd_fifo #(
	parameter int DEPTH = qbr_pkg::CmdDepth
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  qbr_pkg::cmd_t  wr_data,
	output logic           full,
	output logic           rd_valid,
	input  logic           rd_en,
	output qbr_pkg::cmd_t  rd_data
);
	import qbr_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign full     = (cnt_q == CW'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem[rp_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en)
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			if (rd_en)
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			cnt_q <= cnt_q + CW'(wr_en) - CW'(rd_en);
		end
	end
endmodule

// ----- rtl/qbr_back.sv -----
module qbr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  qbr_pkg::cmd_t  cmd,
	output logic           cmd_pop,
	output logic           empty,
	input  logic           pop,
	output logic [1:0]     item_kind,
	output logic [15:0]    out_value,
	output logic           block_last
);
	import qbr_pkg::*;

	logic        res_valid_q;
	logic [1:0]  kind_q;
	logic [15:0] val_q;
	logic        last_q;
	logic [3:0]  sub_q;

	logic        can_load, final_beat;
	logic [1:0]  kind_d;
	logic [15:0] val_d;
	logic        last_d;
	logic [3:0]  sub_m1;

	always_comb begin
		can_load = !res_valid_q || pop;
		sub_m1   = sub_q - 4'd1;
		kind_d   = KIND_WEIGHT;
		val_d    = cmd.val;
		last_d   = 1'b0;
		final_beat = 1'b1;
		case (cmd.op)
			OP_SCALE: kind_d = KIND_SCALE;
			OP_SCALE_BIAS: begin
				final_beat = (sub_q == 4'd1);
				kind_d     = (sub_q == 4'd0) ? KIND_SCALE : KIND_BIAS;
				val_d      = (sub_q == 4'd0) ? cmd.val : cmd.bias;
			end
			OP_BIAS: kind_d = KIND_BIAS;
			OP_BYTE: last_d = cmd.last;
			OP_BYTE_FLUSH: begin
				final_beat = (sub_q == 4'd8);
				last_d     = final_beat;
				if (sub_q != 4'd0)
					val_d = {8'd0, cmd.hi[sub_m1[2:0]]};
			end
			default: ;
		endcase
		cmd_pop = cmd_valid && can_load && final_beat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			sub_q       <= '0;
		end else if (cmd_valid && can_load) begin
			res_valid_q <= 1'b1;
			sub_q       <= final_beat ? 4'd0 : sub_q + 4'd1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && can_load) begin
			kind_q <= kind_d;
			val_q  <= val_d;
			last_q <= last_d;
		end
	end

	assign empty      = !res_valid_q;
	assign item_kind  = kind_q;
	assign out_value  = val_q;
	assign block_last = last_q;
endmodule

// ----- rtl/quant_block_repack_core.sv -----
// Byte-stream repacker for 32-weight quantized blocks (Q4_0, Q4_1, Q8_0, chosen by
// cfg_wdata: 0, 1, 2; 3 acts as Q8_0). A write restarts block alignment. Each
// block gives scale, bias, then its weight beats, block_last on the final one.
// One byte is taken per cycle unless the queue is full; the front classifies it
// into a command queue and the back emits one result beat per cycle while its
// single result register is free or popped. A Q4 eighth low byte yields nine
// beats (low byte plus eight high bytes); the command queue absorbs that burst.
`include "quant_block_repack_core_assert.svh"
module quant_block_repack_core #(
	parameter int CMD_DEPTH = qbr_pkg::CmdDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  raw_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  item_kind,
	output logic [15:0] out_value,
	output logic        block_last
);
	import qbr_pkg::*;

	cmd_t cmd_in, cmd_out;
	logic cmd_push, cmd_full, cmd_valid, cmd_pop, in_fire;

	assign full    = cmd_full;
	assign in_fire = push && !cmd_full;

	qbr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_fire  (in_fire),
		.raw_byte (raw_byte),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	qbr_cmd_fifo #(.DEPTH(CMD_DEPTH)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (cmd_full),
		.rd_valid(cmd_valid),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out)
	);

	qbr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.item_kind (item_kind),
		.out_value (out_value),
		.block_last(block_last)
	);

	`QBR_ASSERT(a_no_push_full, clk, arst_n, !(cmd_push && cmd_full))
	`QBR_ASSERT(a_pop_needs_cmd, clk, arst_n, cmd_pop |-> cmd_valid)
	`QBR_ASSERT(a_last_is_weight, clk, arst_n, (!empty && block_last) |-> (item_kind == KIND_WEIGHT))
	`QBR_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> empty)
endmodule
